// File: hw/rtl/lobs_pkg.sv
package lobs_pkg;

    // Fixed widths of the item fields and registers
    localparam int LEVEL_W        = 10;
    localparam int HOUR_W         = 5;
    localparam int MINUTE_W       = 6;
    localparam int COIL_W         = 4;
    localparam int CFG_TRAVEL_W   = 12;
    localparam int CFG_DATA_W     = 12;
    localparam int CFG_INDEX_W    = 3;
    localparam int PHASE_W        = 3;

    localparam int TRAVEL_BITS_DEFAULT = 12;
    localparam int QUEUE_DEPTH         = 2;

    localparam int MINUTES_PER_HOUR = 60;
    localparam int HOURS_PER_DAY    = 24;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_MODE            = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LUX_LIMIT       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_HR         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_MINUTE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_HR        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_MINUTE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_TRAVEL     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_TRAVEL    = 3'd7;

    // Reset values of the registers
    localparam logic [1:0]              MODE_RESET      = 2'd0;
    localparam logic [LEVEL_W-1:0]      THRESHOLD_RESET = 10'd400;
    localparam logic [HOUR_W-1:0]       OPEN_HR_RESET   = 5'd7;
    localparam logic [MINUTE_W-1:0]     OPEN_MIN_RESET  = 6'd0;
    localparam logic [HOUR_W-1:0]       CLOSE_HR_RESET  = 5'd20;
    localparam logic [MINUTE_W-1:0]     CLOSE_MIN_RESET = 6'd0;
    localparam logic [CFG_TRAVEL_W-1:0] TRAVEL_RESET    = 12'd3000;
    localparam logic [HOUR_W-1:0]       HOUR_RESET      = 5'd7;

    typedef enum logic [1:0] {
        MODE_LIGHT    = 2'd0,
        MODE_SCHEDULE = 2'd1,
        MODE_MANUAL   = 2'd2
    } mode_t;

    typedef enum logic {
        CMD_CONTROL = 1'b0,
        CMD_STEP    = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic               kind;
        logic [LEVEL_W-1:0] light_level;
    } in_item_t;

    typedef struct packed {
        logic [COIL_W-1:0]   coil_pattern;
        logic                blind_open;
        logic                moving;
        logic [HOUR_W-1:0]   hour_now;
        logic [MINUTE_W-1:0] minute_now;
    } out_item_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        cmd_kind_t          kind;
        logic [LEVEL_W-1:0] level;
    } cmd_t;

    typedef struct packed {
        logic [1:0]              mode;
        logic [LEVEL_W-1:0]      lux_limit;
        logic [HOUR_W-1:0]       open_hr;
        logic [MINUTE_W-1:0]     open_minute;
        logic [HOUR_W-1:0]       close_hr;
        logic [MINUTE_W-1:0]     close_minute;
        logic [CFG_TRAVEL_W-1:0] open_travel;
        logic [CFG_TRAVEL_W-1:0] close_travel;
    } cfg_t;

    function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] coils;
        case (phase)
            3'd0:    coils = 4'b1000;
            3'd1:    coils = 4'b1100;
            3'd2:    coils = 4'b0100;
            3'd3:    coils = 4'b0110;
            3'd4:    coils = 4'b0010;
            3'd5:    coils = 4'b0011;
            3'd6:    coils = 4'b0001;
            3'd7:    coils = 4'b1001;
            default: coils = 4'b0000;
        endcase
        return coils;
    endfunction

endpackage

// File: hw/rtl/lobs_front.sv
module lobs_front #(
    parameter int QDEPTH = lobs_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lobs_pkg::in_item_t in_item,
    output logic               q_valid,
    output lobs_pkg::cmd_t     q_cmd,
    input  logic               q_pop
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QDEPTH);

    lobs_pkg::cmd_t   entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    lobs_pkg::cmd_t   cmd_in;
    logic             push;

    // Classify the incoming item
    always_comb
    begin
        cmd_in.kind  = in_item.kind ? lobs_pkg::CMD_STEP : lobs_pkg::CMD_CONTROL;
        cmd_in.level = in_item.light_level;
    end

    assign in_stall = (count_reg == FULL_CNT);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: hw/rtl/lobs_back.sv
module lobs_back #(
    parameter int TRAVEL_BITS = lobs_pkg::TRAVEL_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lobs_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  lobs_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output lobs_pkg::out_item_t out_item
);

    localparam logic [lobs_pkg::MINUTE_W-1:0] LAST_MINUTE =
        lobs_pkg::MINUTE_W'(lobs_pkg::MINUTES_PER_HOUR - 1);
    localparam logic [lobs_pkg::HOUR_W-1:0] LAST_HOUR =
        lobs_pkg::HOUR_W'(lobs_pkg::HOURS_PER_DAY - 1);

    logic                            open_reg, open_next;
    logic [lobs_pkg::PHASE_W-1:0]    phase_reg, phase_next;
    logic [TRAVEL_BITS-1:0]          steps_reg, steps_next;
    logic                            backward_reg, backward_next;
    logic [lobs_pkg::HOUR_W-1:0]     hour_reg, hour_next;
    logic [lobs_pkg::MINUTE_W-1:0]   minute_reg, minute_next;
    logic [lobs_pkg::COIL_W-1:0]     coil_reg, coil_next;
    logic                            out_valid_reg, out_valid_next;
    lobs_pkg::out_item_t             out_item_reg, out_item_next;

    logic                            do_open, do_close;
    logic                            at_open_time, at_close_time;
    lobs_pkg::mode_t                 mode;

    // Take the next item whenever the output register is free or being drained
    assign q_pop = q_valid && (!out_valid_reg || !out_stall);
    assign mode  = lobs_pkg::mode_t'(cfg.mode);

    assign at_open_time  = (hour_reg == cfg.open_hr) && (minute_reg == cfg.open_minute);
    assign at_close_time = (hour_reg == cfg.close_hr) && (minute_reg == cfg.close_minute);

    // Mode decision; opening wins where both conditions hold
    always_comb
    begin
        do_open  = 1'b0;
        do_close = 1'b0;
        case (mode)
            lobs_pkg::MODE_LIGHT:
            begin
                do_open  = (q_cmd.level > cfg.lux_limit) && !open_reg;
                do_close = (q_cmd.level <= cfg.lux_limit) && open_reg;
            end
            lobs_pkg::MODE_SCHEDULE:
            begin
                do_open  = at_open_time && !open_reg;
                do_close = !do_open && at_close_time && open_reg;
            end
            default:
            begin
                do_open  = 1'b0;
                do_close = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        open_next     = open_reg;
        phase_next    = phase_reg;
        steps_next    = steps_reg;
        backward_next = backward_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        coil_next     = coil_reg;
        if (q_pop)
        begin
            case (q_cmd.kind)
                lobs_pkg::CMD_CONTROL:
                begin
                    if (steps_reg == '0)
                    begin
                        if (do_open)
                        begin
                            open_next     = 1'b1;
                            backward_next = 1'b0;
                            steps_next    = TRAVEL_BITS'(cfg.open_travel);
                        end
                        else if (do_close)
                        begin
                            open_next     = 1'b0;
                            backward_next = 1'b1;
                            steps_next    = TRAVEL_BITS'(cfg.close_travel);
                        end
                    end
                    if (minute_reg == LAST_MINUTE)
                    begin
                        minute_next = '0;
                        hour_next   = (hour_reg == LAST_HOUR) ? '0 : hour_reg + 1'b1;
                    end
                    else
                    begin
                        minute_next = minute_reg + 1'b1;
                    end
                end
                lobs_pkg::CMD_STEP:
                begin
                    if (steps_reg != '0)
                    begin
                        phase_next = backward_reg ? phase_reg - 1'b1 : phase_reg + 1'b1;
                        coil_next  = lobs_pkg::half_step(phase_next);
                        steps_next = steps_reg - 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        if (q_pop)
        begin
            out_valid_next             = 1'b1;
            out_item_next.coil_pattern = coil_next;
            out_item_next.blind_open   = open_next;
            out_item_next.moving       = (steps_next != '0);
            out_item_next.hour_now     = hour_next;
            out_item_next.minute_now   = minute_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            phase_reg     <= '0;
            steps_reg     <= '0;
            backward_reg  <= 1'b0;
            hour_reg      <= lobs_pkg::HOUR_RESET;
            minute_reg    <= '0;
            coil_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            open_reg      <= open_next;
            phase_reg     <= phase_next;
            steps_reg     <= steps_next;
            backward_reg  <= backward_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            coil_reg      <= coil_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    // A step tick with travel left counts exactly one step off
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_cmd.kind == lobs_pkg::CMD_STEP && steps_reg != '0)
        |=> steps_reg == $past(steps_reg) - 1'b1)
    else $error("step count did not drop by one");

    // No decision while a move is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_cmd.kind == lobs_pkg::CMD_CONTROL && steps_reg != '0)
        |=> $stable(open_reg) && $stable(backward_reg))
    else $error("direction changed during a move");

    // Clock stays within a day
    assert property (@(posedge clk) disable iff (!rst_n)
        (minute_reg <= LAST_MINUTE) && (hour_reg <= LAST_HOUR))
    else $error("clock out of range");

    // A held result is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !q_pop)
    else $error("item taken while result stalled");

endmodule

// File: hw/rtl/light_or_schedule_blind_stepper.sv
// Window blind stepper controller with a four-coil half-step drive.
//
// Input channel (in_valid / in_stall / in_item): one item per tick. A control
// tick (kind 0) stands for one minute: with no move pending it makes the
// open/close decision from the mode register, then advances the hour/minute
// clock. A step tick (kind 1) moves the coil phase one half step and counts a
// step off the travel; with no travel left it changes nothing.
// Output channel (out_valid / out_stall / out_item): exactly one result per
// item, in order, giving coil drive, blind state, motion and the clock.
// Configuration: cfg_write_en, cfg_index, cfg_data; write only while idle.
//
// An item accepted at a rising edge is written into the queue, popped by the
// back end and registered in the output register before its result is valid.
// Throughput is one item per cycle while out_stall is low, set by the execute
// stage in the back end. A two-entry queue between front and back and the
// output register let each side stall on its own; a stalled result holds
// steady and the queue keeps taking items until it is full, then raises
// in_stall.
// Reset clears the queue and output, loads register defaults, sets the clock
// to 07:00, blind closed, coils off.
module light_or_schedule_blind_stepper #(
    parameter int TRAVEL_BITS = lobs_pkg::TRAVEL_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  lobs_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lobs_pkg::out_item_t                 out_item,
    input  logic                                cfg_write_en,
    input  logic [lobs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lobs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    lobs_pkg::cfg_t cfg_reg, cfg_next;
    logic           q_valid;
    logic           q_pop;
    lobs_pkg::cmd_t q_cmd;

    // Register file: mask each write to its register's width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                lobs_pkg::REG_MODE:
                    cfg_next.mode = cfg_data[1:0];
                lobs_pkg::REG_LUX_LIMIT:
                    cfg_next.lux_limit = cfg_data[lobs_pkg::LEVEL_W-1:0];
                lobs_pkg::REG_OPEN_HR:
                    cfg_next.open_hr = cfg_data[lobs_pkg::HOUR_W-1:0];
                lobs_pkg::REG_OPEN_MINUTE:
                    cfg_next.open_minute = cfg_data[lobs_pkg::MINUTE_W-1:0];
                lobs_pkg::REG_CLOSE_HR:
                    cfg_next.close_hr = cfg_data[lobs_pkg::HOUR_W-1:0];
                lobs_pkg::REG_CLOSE_MINUTE:
                    cfg_next.close_minute = cfg_data[lobs_pkg::MINUTE_W-1:0];
                lobs_pkg::REG_OPEN_TRAVEL:
                    cfg_next.open_travel = cfg_data[lobs_pkg::CFG_TRAVEL_W-1:0];
                lobs_pkg::REG_CLOSE_TRAVEL:
                    cfg_next.close_travel = cfg_data[lobs_pkg::CFG_TRAVEL_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= lobs_pkg::MODE_RESET;
            cfg_reg.lux_limit    <= lobs_pkg::THRESHOLD_RESET;
            cfg_reg.open_hr      <= lobs_pkg::OPEN_HR_RESET;
            cfg_reg.open_minute  <= lobs_pkg::OPEN_MIN_RESET;
            cfg_reg.close_hr     <= lobs_pkg::CLOSE_HR_RESET;
            cfg_reg.close_minute <= lobs_pkg::CLOSE_MIN_RESET;
            cfg_reg.open_travel  <= lobs_pkg::TRAVEL_RESET;
            cfg_reg.close_travel <= lobs_pkg::TRAVEL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept and classify items, hold them in the queue
    lobs_front #(
        .QDEPTH (lobs_pkg::QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    // Back: decide, step the motor, advance the clock, register the result
    lobs_back #(
        .TRAVEL_BITS (TRAVEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// File: tb/sv/light_or_schedule_blind_stepper_tb.sv
`timescale 1ns / 1ps

module light_or_schedule_blind_stepper_tb;

    import lobs_pkg::*;

    // One line of the directed table: either a register write or an item, the
    // latter optionally carrying a hand-written result to expect.
    typedef struct packed {
        bit                      is_write;
        logic [CFG_INDEX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0]   wdata;
        in_item_t                item;
        bit                      typed;
        out_item_t               result;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_item;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Set while neither side may idle
    logic                   steady = 1'b0;

    // Results still owed by the block, oldest first
    out_item_t              pending_status [$];
    stim_row_t              stim_rows [$];
    int                     mismatch_count = 0;

    // Shadow copy of the register file
    logic [1:0]              cfg_mode;
    logic [LEVEL_W-1:0]      cfg_threshold;
    logic [HOUR_W-1:0]       cfg_open_hr;
    logic [MINUTE_W-1:0]     cfg_open_min;
    logic [HOUR_W-1:0]       cfg_close_hr;
    logic [MINUTE_W-1:0]     cfg_close_min;
    logic [CFG_TRAVEL_W-1:0] cfg_open_travel;
    logic [CFG_TRAVEL_W-1:0] cfg_close_travel;

    // Shadow copy of the blind, motor and clock state
    logic                    is_open;
    logic [PHASE_W-1:0]      phase_q;
    logic [CFG_TRAVEL_W-1:0] travel_left;
    logic                    backward;
    logic [HOUR_W-1:0]       hour_q;
    logic [MINUTE_W-1:0]     minute_q;
    logic [COIL_W-1:0]       coils_q;

    // Half-step coil sequence, phase 0 first
    logic [COIL_W-1:0] coil_seq [0:7] = '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

    light_or_schedule_blind_stepper dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit: far beyond the slowest legal run of this stimulus
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver back-pressure: stall about a quarter of the time, never while
    // the steady stretch is on.
    always @(negedge clk)
    begin
        out_stall <= steady ? 1'b0 : ($urandom_range(99) < 24);
    end

    task automatic clear_prediction();
        cfg_mode         = MODE_RESET;
        cfg_threshold    = THRESHOLD_RESET;
        cfg_open_hr      = OPEN_HR_RESET;
        cfg_open_min     = OPEN_MIN_RESET;
        cfg_close_hr     = CLOSE_HR_RESET;
        cfg_close_min    = CLOSE_MIN_RESET;
        cfg_open_travel  = TRAVEL_RESET;
        cfg_close_travel = TRAVEL_RESET;
        is_open          = 1'b0;
        phase_q          = '0;
        travel_left      = '0;
        backward         = 1'b0;
        hour_q           = HOUR_RESET;
        minute_q         = '0;
        coils_q          = '0;
    endtask

    // Start a move: opening runs the phase forward, closing runs it back
    task automatic load_travel(input logic opening);
        is_open     = opening;
        backward    = ~opening;
        travel_left = opening ? cfg_open_travel : cfg_close_travel;
    endtask

    // Work out the status the block reports after one item
    task automatic blind_predict(input in_item_t it, output out_item_t res);
        if (it.kind == CMD_CONTROL)
        begin
            // The mode decision is skipped entirely while a move is still running
            if (travel_left == '0)
            begin
                if (cfg_mode == MODE_LIGHT)
                begin
                    if (it.light_level > cfg_threshold && !is_open)
                        load_travel(1'b1);
                    else if (it.light_level <= cfg_threshold && is_open)
                        load_travel(1'b0);
                end
                else if (cfg_mode == MODE_SCHEDULE)
                begin
                    // Opening wins when both times coincide and the blind is closed
                    if (hour_q == cfg_open_hr && minute_q == cfg_open_min && !is_open)
                        load_travel(1'b1);
                    else if (hour_q == cfg_close_hr && minute_q == cfg_close_min && is_open)
                        load_travel(1'b0);
                end
            end
            // Advance the clock one minute, wrapping hours at midnight
            if (minute_q == MINUTE_W'(MINUTES_PER_HOUR - 1))
            begin
                minute_q = '0;
                hour_q   = (hour_q == HOUR_W'(HOURS_PER_DAY - 1)) ? '0 : hour_q + 1'b1;
            end
            else
            begin
                minute_q = minute_q + 1'b1;
            end
        end
        else if (travel_left != '0)
        begin
            phase_q     = backward ? phase_q - 1'b1 : phase_q + 1'b1;
            coils_q     = coil_seq[phase_q];
            travel_left = travel_left - 1'b1;
        end
        res = '{coil_pattern: coils_q, blind_open: is_open, moving: (travel_left != '0),
                hour_now: hour_q, minute_now: minute_q};
    endtask

    // Write one register once the block has drained. Every item yields a
    // result, so an empty queue plus a short settle means the pipe is idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        case (idx)
            REG_MODE:         cfg_mode         = data[1:0];
            REG_LUX_LIMIT:    cfg_threshold    = data[LEVEL_W-1:0];
            REG_OPEN_HR:      cfg_open_hr      = data[HOUR_W-1:0];
            REG_OPEN_MINUTE:  cfg_open_min     = data[MINUTE_W-1:0];
            REG_CLOSE_HR:     cfg_close_hr     = data[HOUR_W-1:0];
            REG_CLOSE_MINUTE: cfg_close_min    = data[MINUTE_W-1:0];
            REG_OPEN_TRAVEL:  cfg_open_travel  = data[CFG_TRAVEL_W-1:0];
            REG_CLOSE_TRAVEL: cfg_close_travel = data[CFG_TRAVEL_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Offer one item, hold it until taken, then log what must come back.
    // Entered and left at a falling edge.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
        out_item_t res;
        while (!steady && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        blind_predict(it, res);
        pending_status.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    // Random item biased towards the threshold and the level extremes; step
    // ticks are likelier while a move is running so that moves finish.
    function automatic in_item_t random_item(input int busy_pct, input int idle_pct);
        in_item_t it;
        it.kind = ($urandom_range(99) < ((travel_left != '0) ? busy_pct : idle_pct))
                  ? CMD_STEP : CMD_CONTROL;
        case ($urandom_range(4))
            0:       it.light_level = cfg_threshold;
            1:       it.light_level = (cfg_threshold == '1) ? cfg_threshold
                                                             : cfg_threshold + 1'b1;
            2:       it.light_level = '0;
            3:       it.light_level = '1;
            default: it.light_level = LEVEL_W'($urandom);
        endcase
        return it;
    endfunction

    function automatic stim_row_t item_row(input cmd_kind_t kind, input logic [LEVEL_W-1:0] lvl,
                                           input bit typed, input out_item_t res);
        stim_row_t row;
        row          = '0;
        row.item     = '{kind: kind, light_level: lvl};
        row.typed    = typed;
        row.result   = res;
        return row;
    endfunction

    function automatic stim_row_t write_row(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row          = '0;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.wdata    = data;
        return row;
    endfunction

    // One random setting of all registers, then a burst of items. Schedule
    // times are mostly placed a few minutes ahead of the clock so that they hit.
    task automatic random_phase(input int n_items);
        logic [HOUR_W-1:0]   at_hour;
        logic [MINUTE_W-1:0] at_min;
        write_reg(REG_MODE, CFG_DATA_W'($urandom_range(3)));
        case ($urandom_range(2))
            0:       write_reg(REG_LUX_LIMIT, '0);
            1:       write_reg(REG_LUX_LIMIT, CFG_DATA_W'(1023));
            default: write_reg(REG_LUX_LIMIT, CFG_DATA_W'($urandom_range(1023)));
        endcase
        if ($urandom_range(3) == 0)
        begin
            at_hour = HOUR_W'($urandom_range(23));
            at_min  = ($urandom_range(1) == 0) ? '0 : MINUTE_W'(59);
        end
        else
        begin
            at_hour = hour_q;
            at_min  = MINUTE_W'((int'(minute_q) + $urandom_range(4, 1)) % 60);
        end
        write_reg(REG_OPEN_HR, CFG_DATA_W'(at_hour));
        write_reg(REG_OPEN_MINUTE, CFG_DATA_W'(at_min));
        // A zero offset makes the open and close times coincide
        write_reg(REG_CLOSE_HR, CFG_DATA_W'(at_hour));
        write_reg(REG_CLOSE_MINUTE, CFG_DATA_W'((int'(at_min) + $urandom_range(4)) % 60));
        write_reg(REG_OPEN_TRAVEL, CFG_DATA_W'($urandom_range(6)));
        write_reg(REG_CLOSE_TRAVEL, CFG_DATA_W'($urandom_range(6)));
        repeat (n_items)
            send_item(random_item(60, 25), 1'b0, '0);
    endtask

    // Compare each accepted result with the oldest one owed
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                $error("unexpected result %h with nothing outstanding", out_item);
                mismatch_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                if (out_item.coil_pattern !== want.coil_pattern)
                begin
                    $error("coil_pattern: expected %h, got %h",
                           want.coil_pattern, out_item.coil_pattern);
                    mismatch_count++;
                end
                if (out_item.blind_open !== want.blind_open)
                begin
                    $error("blind_open: expected %b, got %b",
                           want.blind_open, out_item.blind_open);
                    mismatch_count++;
                end
                if (out_item.moving !== want.moving)
                begin
                    $error("moving: expected %b, got %b", want.moving, out_item.moving);
                    mismatch_count++;
                end
                if (out_item.hour_now !== want.hour_now)
                begin
                    $error("hour_now: expected %0d, got %0d", want.hour_now, out_item.hour_now);
                    mismatch_count++;
                end
                if (out_item.minute_now !== want.minute_now)
                begin
                    $error("minute_now: expected %0d, got %0d",
                           want.minute_now, out_item.minute_now);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        in_item_t it;
        int       n_ctrl;
        int       n_limit;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_MODE;
        cfg_data     = '0;
        clear_prediction();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table. The clock starts at 07:00 in light mode with a
        // threshold of 400; the comments track the clock before each tick.
        // Idle step tick straight after reset: nothing moves, coils off
        stim_rows.push_back(item_row(CMD_STEP, 10'd0, 1'b1,
                                     out_item_t'{4'h0, 1'b0, 1'b0, 5'd7, 6'd0}));
        // Light exactly at the threshold keeps a closed blind closed
        stim_rows.push_back(item_row(CMD_CONTROL, 10'd400, 1'b1,
                                     out_item_t'{4'h0, 1'b0, 1'b0, 5'd7, 6'd1}));
        stim_rows.push_back(write_row(REG_OPEN_TRAVEL, 12'd2));
        stim_rows.push_back(write_row(REG_CLOSE_TRAVEL, 12'd0));
        // One above the threshold opens: two steps pending (07:01)
        stim_rows.push_back(item_row(CMD_CONTROL, 10'd401, 1'b1,
                                     out_item_t'{4'h0, 1'b1, 1'b1, 5'd7, 6'd2}));
        // Dark while still moving: decision skipped, clock still runs
        stim_rows.push_back(item_row(CMD_CONTROL, 10'd0, 1'b0, '0));
        stim_rows.push_back(item_row(CMD_STEP, 10'd0, 1'b0, '0));
        stim_rows.push_back(item_row(CMD_STEP, 10'h3FF, 1'b0, '0));
        // Travel used up: idle step tick
        stim_rows.push_back(item_row(CMD_STEP, 10'd0, 1'b0, '0));
        stim_rows.push_back(item_row(CMD_CONTROL, 10'h3FF, 1'b0, '0));
        // Close with zero travel: state flips, no motion (07:04)
        stim_rows.push_back(item_row(CMD_CONTROL, 10'd0, 1'b0, '0));
        // Unused mode code behaves as manual
        stim_rows.push_back(write_row(REG_MODE, 12'd3));
        stim_rows.push_back(item_row(CMD_CONTROL, 10'h3FF, 1'b0, '0));
        stim_rows.push_back(write_row(REG_MODE, CFG_DATA_W'(MODE_MANUAL)));
        stim_rows.push_back(item_row(CMD_CONTROL, 10'h3FF, 1'b0, '0));
        // Schedule with open and close both at 07:08 (clock now 07:07)
        stim_rows.push_back(write_row(REG_MODE, CFG_DATA_W'(MODE_SCHEDULE)));
        stim_rows.push_back(write_row(REG_OPEN_HR, 12'd7));
        stim_rows.push_back(write_row(REG_OPEN_MINUTE, 12'd8));
        stim_rows.push_back(write_row(REG_CLOSE_HR, 12'd7));
        stim_rows.push_back(write_row(REG_CLOSE_MINUTE, 12'd8));
        stim_rows.push_back(write_row(REG_OPEN_TRAVEL, 12'd1));
        stim_rows.push_back(write_row(REG_CLOSE_TRAVEL, 12'd1));
        stim_rows.push_back(item_row(CMD_CONTROL, 10'd0, 1'b0, '0));
        // Coinciding times while closed: only the opening happens
        stim_rows.push_back(item_row(CMD_CONTROL, 10'd0, 1'b0, '0));
        stim_rows.push_back(item_row(CMD_STEP, 10'd0, 1'b0, '0));
        // Move the close time to 07:10 and let the clock reach it
        stim_rows.push_back(write_row(REG_CLOSE_MINUTE, 12'd10));
        stim_rows.push_back(item_row(CMD_CONTROL, 10'd0, 1'b0, '0));
        stim_rows.push_back(item_row(CMD_CONTROL, 10'd0, 1'b0, '0));
        stim_rows.push_back(item_row(CMD_STEP, 10'd0, 1'b0, '0));
        // Threshold extremes in light mode
        stim_rows.push_back(write_row(REG_MODE, CFG_DATA_W'(MODE_LIGHT)));
        stim_rows.push_back(write_row(REG_LUX_LIMIT, 12'd0));
        stim_rows.push_back(item_row(CMD_CONTROL, 10'd0, 1'b0, '0));
        stim_rows.push_back(item_row(CMD_CONTROL, 10'd1, 1'b0, '0));
        stim_rows.push_back(item_row(CMD_STEP, 10'd0, 1'b0, '0));
        stim_rows.push_back(write_row(REG_LUX_LIMIT, 12'd1023));
        stim_rows.push_back(item_row(CMD_CONTROL, 10'h3FF, 1'b0, '0));
        stim_rows.push_back(item_row(CMD_STEP, 10'd0, 1'b0, '0));

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_write)
                write_reg(stim_rows[i].reg_idx, stim_rows[i].wdata);
            else
                send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].result);
        end

        // Random settings with bursts of items; one burst runs with no idling
        for (int p = 0; p < 8; p++)
        begin
            steady <= (p == 4);
            random_phase(30);
        end
        steady <= 1'b0;

        // Long travel both ways: the phase walks the whole table three times
        // in each direction. Hold the steady stretch on the way out.
        write_reg(REG_MODE, CFG_DATA_W'(MODE_LIGHT));
        write_reg(REG_LUX_LIMIT, 12'd512);
        write_reg(REG_OPEN_TRAVEL, 12'd24);
        write_reg(REG_CLOSE_TRAVEL, 12'd24);
        if (is_open)
        begin
            send_item('{kind: CMD_CONTROL, light_level: 10'd0}, 1'b0, '0);
            while (travel_left != '0)
                send_item(random_item(97, 0), 1'b0, '0);
        end
        steady <= 1'b1;
        send_item('{kind: CMD_CONTROL, light_level: 10'h3FF}, 1'b0, '0);
        while (travel_left != '0)
            send_item(random_item(97, 0), 1'b0, '0);
        steady <= 1'b0;
        send_item('{kind: CMD_CONTROL, light_level: 10'd0}, 1'b0, '0);
        while (travel_left != '0)
            send_item(random_item(97, 0), 1'b0, '0);

        // Schedule across the next hour wrap: open at minute 59 of the
        // current hour, close on the hour that follows.
        write_reg(REG_MODE, CFG_DATA_W'(MODE_SCHEDULE));
        write_reg(REG_OPEN_HR, CFG_DATA_W'(hour_q));
        write_reg(REG_OPEN_MINUTE, 12'd59);
        write_reg(REG_CLOSE_HR, CFG_DATA_W'((int'(hour_q) + 1) % HOURS_PER_DAY));
        write_reg(REG_CLOSE_MINUTE, 12'd0);
        write_reg(REG_OPEN_TRAVEL, 12'd0);
        write_reg(REG_CLOSE_TRAVEL, 12'd2);
        n_limit = MINUTES_PER_HOUR + 2 - int'(minute_q);
        n_ctrl  = 0;
        while (n_ctrl < n_limit)
        begin
            it = random_item(70, 15);
            if (it.kind == CMD_CONTROL)
                n_ctrl++;
            send_item(it, 1'b0, '0);
        end

        // Drain: wait for every owed result, then let the block settle
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/lobs_pkg.sv
hw/rtl/lobs_front.sv
hw/rtl/lobs_back.sv
hw/rtl/light_or_schedule_blind_stepper.sv
tb/sv/light_or_schedule_blind_stepper_tb.sv
